[hw/rtl/dns_query_packet_builder_defines.svh]
// assertion helpers for the query builder
`ifndef DNS_QUERY_PACKET_BUILDER_DEFINES_SVH
`define DNS_QUERY_PACKET_BUILDER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DQPB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define DQPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dqpb_pkg.sv]
`timescale 1ns / 1ps

package dqpb_pkg;

  localparam int unsigned NAME_MAX_LEN_DEF = 255;
  localparam int unsigned PACKET_BYTES_DEF = 512;
  localparam int unsigned CMD_DEPTH_DEF    = 4;

  typedef logic [8:0] off_t;
  typedef logic [7:0] byte_t;
  typedef logic [3:0] beat_t;

  localparam off_t  HDR_LEN    = 9'd12;
  localparam byte_t DOT_CHAR   = 8'h2E;
  localparam byte_t CLASS_IN   = 8'h01;
  localparam byte_t RD_FLAG_HI = 8'h01;
  localparam byte_t QDCOUNT_LO = 8'h01;

  // header beat positions
  localparam beat_t HDR_ID_HI      = 4'd0;
  localparam beat_t HDR_ID_LO      = 4'd1;
  localparam beat_t HDR_FLAGS_HI   = 4'd2;
  localparam beat_t HDR_QDCOUNT_LO = 4'd5;
  localparam beat_t HDR_LAST_BEAT  = 4'd11;

  // question tail beat positions
  localparam beat_t TAIL_QTYPE_HI = 4'd0;
  localparam beat_t TAIL_QTYPE_LO = 4'd1;
  localparam beat_t TAIL_CLASS_HI = 4'd2;
  localparam beat_t TAIL_LAST_BEAT = 4'd3;

  // at most one command per character, expanded into bytes by the back end
  typedef struct packed {
    logic        hdr;
    logic [15:0] id;
    logic        body_en;
    off_t        body_off;
    byte_t       body_byte;
    logic        fill0_en;
    off_t        fill0_off;
    byte_t       fill0_byte;
    logic        fill1_en;
    off_t        fill1_off;
    logic        tail_en;
    off_t        tail_off;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_BODY,
    PH_FILL0,
    PH_FILL1,
    PH_TAIL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic in_name;
  } front_status_t;

endpackage

[hw/rtl/dqpb_front.sv]
`timescale 1ns / 1ps

module dqpb_front #(
  parameter int unsigned NAME_MAX_LEN = dqpb_pkg::NAME_MAX_LEN_DEF,
  parameter int unsigned PACKET_BYTES = dqpb_pkg::PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            name_char,
  input  logic                  name_last,
  input  logic [15:0]           query_id,
  output dqpb_pkg::cmd_t        cmd,
  output logic                  cmd_valid,
  output dqpb_pkg::front_status_t status
);
  import dqpb_pkg::*;

  logic in_name, in_name_next;
  off_t write_pos, write_pos_next;
  off_t label_start, label_start_next;

  logic  first;
  logic  is_dot;
  logic  fits;
  off_t  wp_eff;
  off_t  ls_eff;
  off_t  taken;
  off_t  len_open;
  off_t  len_close;
  off_t  wp1;
  off_t  ls1;

  always_comb begin
    first  = !in_name;
    is_dot = (name_char == DOT_CHAR);
    wp_eff = first ? (HDR_LEN + 9'd1) : write_pos;
    ls_eff = first ? HDR_LEN : label_start;
    taken  = wp_eff - (HDR_LEN + 9'd1);
    fits   = (32'(taken) < NAME_MAX_LEN) && (32'(wp_eff) + 32'd6 <= PACKET_BYTES);
    len_open = wp_eff - ls_eff - 9'd1;

    cmd = '0;
    cmd.hdr = first;
    cmd.id  = query_id;

    wp1 = wp_eff;
    ls1 = ls_eff;
    if (fits) begin
      cmd.body_en = 1'b1;
      wp1 = wp_eff + 9'd1;
      if (is_dot) begin
        cmd.body_off  = ls_eff;
        cmd.body_byte = len_open[7:0];
        ls1 = wp_eff;
      end else begin
        cmd.body_off  = wp_eff;
        cmd.body_byte = name_char;
      end
    end

    len_close = wp1 - ls1 - 9'd1;
    if (name_last) begin
      cmd.tail_en = 1'b1;
      if (wp1 == ls1 + 9'd1) begin
        // empty open label: its slot becomes the terminator
        if (first && is_dot) begin
          cmd.tail_off = ls1;
        end else begin
          cmd.fill0_en   = 1'b1;
          cmd.fill0_off  = ls1;
          cmd.fill0_byte = '0;
          cmd.tail_off   = ls1 + 9'd1;
        end
      end else begin
        cmd.fill0_en   = 1'b1;
        cmd.fill0_off  = ls1;
        cmd.fill0_byte = len_close[7:0];
        cmd.fill1_en   = 1'b1;
        cmd.fill1_off  = wp1;
        cmd.tail_off   = wp1 + 9'd1;
      end
    end

    // a dropped middle character makes no bytes at all
    cmd_valid = first || fits || name_last;

    in_name_next     = in_name;
    write_pos_next   = write_pos;
    label_start_next = label_start;
    if (accept) begin
      if (name_last) begin
        in_name_next     = 1'b0;
        write_pos_next   = '0;
        label_start_next = '0;
      end else begin
        in_name_next     = 1'b1;
        write_pos_next   = wp1;
        label_start_next = ls1;
      end
    end

    status.in_name = in_name;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_name     <= 1'b0;
      write_pos   <= '0;
      label_start <= '0;
    end else begin
      in_name     <= in_name_next;
      write_pos   <= write_pos_next;
      label_start <= label_start_next;
    end
  end

endmodule

[hw/rtl/dqpb_fifo.sv]
`timescale 1ns / 1ps

module dqpb_fifo #(
  parameter int unsigned DEPTH = dqpb_pkg::CMD_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  dqpb_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output dqpb_pkg::cmd_t rd_data,
  output logic           not_empty
);
  import dqpb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          do_wr;
  logic          do_rd;

  always_comb begin
    full      = (count == CW'(DEPTH));
    not_empty = (count != '0);
    do_wr     = wr_en && !full;
    do_rd     = rd_en && not_empty;
    rd_data   = slots[rd_ptr];

    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (do_wr) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end

    count_next = count;
    if (do_wr && !do_rd) begin
      count_next = count + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

[hw/rtl/dqpb_back.sv]
`timescale 1ns / 1ps

module dqpb_back (
  input  logic           clk,
  input  logic           rst,
  input  dqpb_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  logic [15:0]    query_type,
  input  logic           pop,
  output logic           empty,
  output logic [8:0]     byte_offset,
  output logic [7:0]     packet_byte,
  output logic           packet_done
);
  import dqpb_pkg::*;

  // first enabled part of a command at or after a given phase
  function automatic phase_t next_phase(cmd_t c, phase_t from);
    phase_t p;
    p = PH_DONE;
    if (from <= PH_TAIL && c.tail_en) p = PH_TAIL;
    if (from <= PH_FILL1 && c.fill1_en) p = PH_FILL1;
    if (from <= PH_FILL0 && c.fill0_en) p = PH_FILL0;
    if (from <= PH_BODY && c.body_en) p = PH_BODY;
    if (from <= PH_HDR && c.hdr) p = PH_HDR;
    return p;
  endfunction

  phase_t ph, ph_next;
  logic   started, started_next;
  beat_t  beat, beat_next;

  logic   out_valid, out_valid_next;
  off_t   out_off;
  byte_t  out_byte;
  logic   out_done;

  phase_t cur;
  phase_t nxt;
  logic   advance;
  logic   stay;
  off_t   sel_off;
  byte_t  sel_byte;
  logic   sel_done;

  always_comb begin
    cur     = started ? ph : next_phase(cmd, PH_HDR);
    nxt     = next_phase(cmd, phase_t'(3'(cur) + 3'd1));
    advance = cmd_valid && (!out_valid || pop);

    sel_off  = '0;
    sel_byte = '0;
    sel_done = 1'b0;
    stay     = 1'b0;
    case (cur)
      PH_HDR: begin
        sel_off = {5'b0, beat};
        stay    = (beat != HDR_LAST_BEAT);
        case (beat)
          HDR_ID_HI:      sel_byte = cmd.id[15:8];
          HDR_ID_LO:      sel_byte = cmd.id[7:0];
          HDR_FLAGS_HI:   sel_byte = RD_FLAG_HI;
          HDR_QDCOUNT_LO: sel_byte = QDCOUNT_LO;
          default:        sel_byte = '0;
        endcase
      end
      PH_BODY: begin
        sel_off  = cmd.body_off;
        sel_byte = cmd.body_byte;
      end
      PH_FILL0: begin
        sel_off  = cmd.fill0_off;
        sel_byte = cmd.fill0_byte;
      end
      PH_FILL1: begin
        sel_off  = cmd.fill1_off;
        sel_byte = '0;
      end
      PH_TAIL: begin
        sel_off = cmd.tail_off + {5'b0, beat};
        stay    = (beat != TAIL_LAST_BEAT);
        case (beat)
          TAIL_QTYPE_HI: sel_byte = query_type[15:8];
          TAIL_QTYPE_LO: sel_byte = query_type[7:0];
          TAIL_CLASS_HI: sel_byte = '0;
          default: begin
            sel_byte = CLASS_IN;
            sel_done = 1'b1;
          end
        endcase
      end
      default: begin
        sel_off  = '0;
        sel_byte = '0;
      end
    endcase

    ph_next      = ph;
    started_next = started;
    beat_next    = beat;
    cmd_pop      = 1'b0;
    if (advance) begin
      if (stay) begin
        ph_next      = cur;
        started_next = 1'b1;
        beat_next    = beat + 4'd1;
      end else if (nxt == PH_DONE) begin
        cmd_pop      = 1'b1;
        ph_next      = PH_HDR;
        started_next = 1'b0;
        beat_next    = '0;
      end else begin
        ph_next      = nxt;
        started_next = 1'b1;
        beat_next    = '0;
      end
    end

    if (advance) begin
      out_valid_next = 1'b1;
    end else if (pop) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    empty       = !out_valid;
    byte_offset = out_off;
    packet_byte = out_byte;
    packet_done = out_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph        <= PH_HDR;
      started   <= 1'b0;
      beat      <= '0;
      out_valid <= 1'b0;
    end else begin
      ph        <= ph_next;
      started   <= started_next;
      beat      <= beat_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_off  <= sel_off;
      out_byte <= sel_byte;
      out_done <= sel_done;
    end
  end

endmodule

[hw/rtl/dns_query_packet_builder.sv]
// DNS query packet builder. Feed the characters of a dotted domain name one word per
// clock (push/full), marking the final one with name_last; query_id is taken with the
// first character. Out comes a standard query as (byte_offset, packet_byte) words
// (empty/pop): the 12-byte header on the first character, one byte per kept character,
// label length bytes back-filled on each dot and at the end, then the zero terminator,
// query_type and class IN, with packet_done on the last byte (length = offset + 1).
// Words come out in the order they are generated, not in offset order. The front end
// classifies each character combinationally into at most one command and takes a new
// character every clock while the CMD_DEPTH-entry command queue has room. The back end
// expands commands at one output word per clock while the output is empty or popped,
// which sets the throughput: a kept inner character yields one word, the first 13, the
// last up to 6 more (at most 19 words for a one-character name); the output is registered.
// query_type may be rewritten only while the block is idle.
`timescale 1ns / 1ps
`include "dns_query_packet_builder_defines.svh"

module dns_query_packet_builder #(
  parameter int unsigned NAME_MAX_LEN = dqpb_pkg::NAME_MAX_LEN_DEF,
  parameter int unsigned PACKET_BYTES = dqpb_pkg::PACKET_BYTES_DEF,
  parameter int unsigned CMD_DEPTH    = dqpb_pkg::CMD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // character input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  name_char,
  input  logic        name_last,
  input  logic [15:0] query_id,
  // configuration
  input  logic        query_type_we,
  input  logic [15:0] query_type,
  // packet byte output
  output logic        empty,
  input  logic        pop,
  output logic [8:0]  byte_offset,
  output logic [7:0]  packet_byte,
  output logic        packet_done
);
  import dqpb_pkg::*;

  // record type register, A by default
  logic [15:0] qtype_reg;

  logic          in_accept;
  cmd_t          front_cmd;
  logic          front_cmd_valid;
  logic          cmd_push;
  front_status_t front_status;
  cmd_t          head_cmd;
  logic          head_valid;
  logic          head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      qtype_reg <= 16'd1;
    end else if (query_type_we) begin
      qtype_reg <= query_type;
    end
  end

  assign in_accept = push && !full;
  // only characters that make bytes enter the queue
  assign cmd_push  = in_accept && front_cmd_valid;

  // front end: name tracking and per-character classification
  dqpb_front #(
    .NAME_MAX_LEN (NAME_MAX_LEN),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .name_char (name_char),
    .name_last (name_last),
    .query_id  (query_id),
    .cmd       (front_cmd),
    .cmd_valid (front_cmd_valid),
    .status    (front_status)
  );

  // decoupling queue between the two halves
  dqpb_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_data   (front_cmd),
    .full      (full),
    .rd_en     (head_pop),
    .rd_data   (head_cmd),
    .not_empty (head_valid)
  );

  // back end: command expansion into packet bytes
  dqpb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (head_cmd),
    .cmd_valid   (head_valid),
    .cmd_pop     (head_pop),
    .query_type  (qtype_reg),
    .pop         (pop),
    .empty       (empty),
    .byte_offset (byte_offset),
    .packet_byte (packet_byte),
    .packet_done (packet_done)
  );

  // the first character of a name always queues the header
  `DQPB_ASSERT_NOW(a_first_pushes, in_accept && !front_status.in_name, cmd_push, "first character lost")

  // a name ends on its last character
  `DQPB_ASSERT_NEXT(a_last_closes, in_accept && name_last, !front_status.in_name, "name not closed")

  // the closing word is always the class low byte
  `DQPB_ASSERT_NOW(a_done_class, !empty && packet_done, packet_byte == CLASS_IN, "bad final word")

endmodule

[test/dns_query_packet_builder_tb.sv]
`timescale 1ns / 1ps

module dns_query_packet_builder_tb;
  import dqpb_pkg::*;

  localparam int NAME_MAX     = NAME_MAX_LEN_DEF;
  localparam int PKT_BYTES    = PACKET_BYTES_DEF;
  localparam int QUIET_CYCLES = 16;    // covers a dropped char still in flight
  localparam int DRAIN_CYCLES = 40;    // tail after the last expected word
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 3000;  // watchdog, cycles with no word moving
  localparam int RANDOM_CHARS = 24;
  localparam int MAX_PRINTS   = 20;

  // one packet byte as the block should hand it out
  typedef struct packed {
    off_t  offset;
    byte_t value;
    logic  done;
  } pkt_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  name_char = 8'h00;
  logic        name_last = 1'b0;
  logic [15:0] query_id = 16'h0000;
  logic        query_type_we = 1'b0;
  logic [15:0] query_type = 16'h0000;
  logic        empty;
  logic        pop = 1'b0;
  logic [8:0]  byte_offset;
  logic [7:0]  packet_byte;
  logic        packet_done;

  // shadow of the builder state and its register
  logic        name_open = 1'b0;
  int          next_pos = 0;
  int          label_pos = 0;
  logic [15:0] qtype_shadow = 16'd1;

  pkt_byte_t   pending_pkt_bytes[$];
  byte_t       name_buf[$];

  int mismatches = 0;
  int chars_sent = 0;
  int names_sent = 0;
  int bytes_checked = 0;
  int qtype_writes = 0;
  int holds_done = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  dns_query_packet_builder u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .name_char    (name_char),
    .name_last    (name_last),
    .query_id     (query_id),
    .query_type_we(query_type_we),
    .query_type   (query_type),
    .empty        (empty),
    .pop          (pop),
    .byte_offset  (byte_offset),
    .packet_byte  (packet_byte),
    .packet_done  (packet_done)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic void add_byte(input int off, input int val, input logic done);
    pkt_byte_t b;
    b.offset = off_t'(off);
    b.value  = byte_t'(val);
    b.done   = done;
    pending_pkt_bytes.push_back(b);
  endfunction

  // bytes a character produces, following the encoder's rules
  task automatic build_query(input byte_t c, input logic last, input logic [15:0] id);
    logic first;
    int   taken;
    int   tail;
    first = !name_open;
    if (first) begin
      // 12-byte header: id, flags with rd only, qdcount 1, zero counts
      for (int k = 0; k < int'(HDR_LEN); k++) begin
        case (k)
          int'(HDR_ID_HI):      add_byte(k, id[15:8], 1'b0);
          int'(HDR_ID_LO):      add_byte(k, id[7:0], 1'b0);
          int'(HDR_FLAGS_HI):   add_byte(k, RD_FLAG_HI, 1'b0);
          int'(HDR_QDCOUNT_LO): add_byte(k, QDCOUNT_LO, 1'b0);
          default:              add_byte(k, 0, 1'b0);
        endcase
      end
      label_pos = int'(HDR_LEN);
      next_pos  = int'(HDR_LEN) + 1;
      name_open = 1'b1;
    end
    taken = next_pos - (int'(HDR_LEN) + 1);
    // overlong names drop characters but a last one still closes the packet
    if (taken < NAME_MAX && next_pos + 6 <= PKT_BYTES) begin
      if (c == DOT_CHAR) begin
        add_byte(label_pos, (next_pos - label_pos - 1) & 8'hFF, 1'b0);
        label_pos = next_pos;
      end else begin
        add_byte(next_pos, c, 1'b0);
      end
      next_pos++;
    end
    if (last) begin
      if (next_pos == label_pos + 1) begin
        // empty open label: its length slot is the terminator
        if (first && c == DOT_CHAR) begin
          tail = label_pos;
        end else begin
          add_byte(label_pos, 0, 1'b0);
          tail = label_pos + 1;
        end
      end else begin
        add_byte(label_pos, (next_pos - label_pos - 1) & 8'hFF, 1'b0);
        add_byte(next_pos, 0, 1'b0);
        tail = next_pos + 1;
      end
      add_byte(tail, qtype_shadow[15:8], 1'b0);
      add_byte(tail + 1, qtype_shadow[7:0], 1'b0);
      add_byte(tail + 2, 0, 1'b0);
      add_byte(tail + 3, CLASS_IN, 1'b1);
      name_open = 1'b0;
      next_pos  = 0;
      label_pos = 0;
    end
  endtask

  // one character word; called at a rising edge, returns at its accept edge
  task automatic send_char(input byte_t c, input logic last, input logic [15:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push      <= 1'b1;
    name_char <= c;
    name_last <= last;
    query_id  <= id;
    do @(posedge clk); while (full);
    build_query(c, last, id);
    chars_sent++;
  endtask

  // sends name_buf, the first character carrying the given id
  task automatic send_name(input logic [15:0] first_id);
    for (int i = 0; i < name_buf.size(); i++)
      send_char(name_buf[i], i == name_buf.size() - 1,
                (i == 0) ? first_id : 16'($urandom_range(0, 65535)));
    names_sent++;
  endtask

  task automatic load_name(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
  endtask

  // register write only once the block has gone quiet
  task automatic set_query_type(input logic [15:0] v);
    push <= 1'b0;
    while (pending_pkt_bytes.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    query_type_we <= 1'b1;
    query_type    <= v;
    @(posedge clk);
    query_type_we <= 1'b0;
    qtype_shadow = v;
    qtype_writes++;
  endtask

  function automatic byte_t rand_letter();
    byte_t v;
    v = byte_t'($urandom_range(0, 255));
    return (v == DOT_CHAR) ? 8'h61 : v;
  endfunction

  // regular dotted name, labels of 1..max_len non-dot bytes, sometimes a trailing dot
  task automatic make_regular_name(input int max_len);
    int labels;
    name_buf.delete();
    labels = $urandom_range(1, 4);
    for (int l = 0; l < labels; l++) begin
      if (l != 0) name_buf.push_back(DOT_CHAR);
      repeat ($urandom_range(1, max_len)) name_buf.push_back(rand_letter());
    end
    if ($urandom_range(0, 5) == 0) name_buf.push_back(DOT_CHAR);
  endtask

  // ---------------------------------------------------------------- tests

  // reset query type, single letter, all-ones id
  task automatic test_single_char_defaults();
    load_name("a");
    send_name(16'hFFFF);
  endtask

  // root name: one dot, no extra terminator
  task automatic test_root_name();
    load_name(".");
    send_name(16'h0000);
  endtask

  task automatic test_trailing_dot();
    load_name("ab.");
    send_name(16'h1234);
  endtask

  // empty labels just get length zero
  task automatic test_empty_labels();
    load_name("a..b");
    send_name(16'h8001);
    load_name(".x");
    send_name(16'h7FFE);
    load_name("..");
    send_name(16'h00FF);
  endtask

  // char codes at the edges and around the dot
  task automatic test_char_extremes();
    name_buf.delete();
    name_buf.push_back(8'h00);
    name_buf.push_back(8'hFF);
    name_buf.push_back(DOT_CHAR);
    name_buf.push_back(8'h2D);
    name_buf.push_back(8'h2F);
    send_name(16'h5AA5);
  endtask

  task automatic test_query_type_extremes();
    set_query_type(16'hFFFF);
    load_name("x.y");
    send_name(16'hA5A5);
    set_query_type(16'h0000);
    load_name("z");
    send_name(16'hFF00);
  endtask

  // name past the length cap: extra chars drop, a dropped last one still ends it
  task automatic test_overlong_name();
    set_query_type(16'd15);
    name_buf.delete();
    repeat (NAME_MAX) name_buf.push_back(rand_letter());
    name_buf.push_back(8'h78);
    name_buf.push_back(8'h79);
    name_buf.push_back(DOT_CHAR);
    send_name(16'($urandom_range(0, 65535)));
  endtask

  // receiver holds off while names keep coming, so the input side stalls
  task automatic test_backpressure();
    int start;
    set_query_type(16'd28);
    start = chars_sent;
    hold_request = 1'b1;
    while (chars_sent < start + 24) begin
      make_regular_name(8);
      send_name(16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_random_names();
    int start;
    int kind;
    start = chars_sent;
    while (chars_sent < start + RANDOM_CHARS) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        load_name(".");
      end else if (kind <= 2) begin
        // noise: any byte, dots included, empty labels likely
        name_buf.delete();
        repeat ($urandom_range(1, 10))
          name_buf.push_back(($urandom_range(0, 3) == 0) ? DOT_CHAR
                                                          : byte_t'($urandom_range(0, 255)));
      end else begin
        make_regular_name(8);
      end
      send_name(16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       set_query_type(16'h0000);
          1:       set_query_type(16'hFFFF);
          default: set_query_type(16'($urandom_range(0, 65535)));
        endcase
      end
    end
  endtask

  // ------------------------------------------------------------- receiver

  task automatic check_word();
    pkt_byte_t want;
    if (pending_pkt_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected word off=%0d byte=%02h done=%0b",
                                byte_offset, packet_byte, packet_done));
    end else begin
      want = pending_pkt_bytes.pop_front();
      bytes_checked++;
      if (byte_offset !== want.offset)
        report_mismatch($sformatf("byte_offset %0d, want %0d", byte_offset, want.offset));
      if (packet_byte !== want.value)
        report_mismatch($sformatf("packet_byte %02h at off %0d, want %02h",
                                  packet_byte, want.offset, want.value));
      if (packet_done !== want.done)
        report_mismatch($sformatf("packet_done %0b at off %0d, want %0b",
                                  packet_done, want.offset, want.done));
    end
  endtask

  // pops in on/off runs of random length, plus the long hold-off on request
  initial begin
    int   run_left;
    int   hold_left;
    logic run_pop;
    run_left  = 0;
    hold_left = 0;
    run_pop   = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) check_word();
      if (!rst) begin
        if (hold_request) begin
          hold_request = 1'b0;
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
        if (hold_left > 0) begin
          hold_left--;
          pop <= 1'b0;
        end else begin
          if (run_left == 0) begin
            run_pop  = ($urandom_range(0, 2) != 0);
            run_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 8);
          end
          run_left--;
          pop <= run_pop;
        end
      end
    end
  end

  // watchdog: too long with no word moving either way
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ----------------------------------------------------------------- main

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_single_char_defaults();
    test_root_name();
    test_trailing_dot();
    test_empty_labels();
    test_char_extremes();
    test_query_type_extremes();
    test_overlong_name();
    test_backpressure();
    test_random_names();

    // let everything drain, then a short quiet tail
    push <= 1'b0;
    while (pending_pkt_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d names, %0d characters, %0d packet bytes checked",
             names_sent, chars_sent, bytes_checked);
    $display("query type writes %0d, receiver hold-offs %0d, mismatches %0d",
             qtype_writes, holds_done, mismatches);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
